[design/wavetable_voice_mixer_defines.svh]
// Assertion macros used by the checker file.
`ifndef WAVETABLE_VOICE_MIXER_DEFINES_SVH
`define WAVETABLE_VOICE_MIXER_DEFINES_SVH

// Same-cycle implication.
`define WVM_ASSERT_SAME(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("wvm check failed");

// Next-cycle implication.
`define WVM_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("wvm check failed");

`endif

[design/wvm_pkg.sv]
package wvm_pkg;

  localparam int VOICES_DEF       = 4;
  localparam int FRAC_BITS_DEF    = 12;
  localparam int ADDR_BITS_DEF    = 16;
  localparam int VOLUME_SHIFT_DEF = 0;

  localparam int EIGHT_SHIFT = 6;
  localparam int SAT16_MAX   = 32767;
  localparam int SAT16_MIN   = -32768;
  localparam int SAT8_MAX    = 127;
  localparam int SAT8_MIN    = -128;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_TRIGGER = 2'd1,
    OP_UPDATE  = 2'd2,
    OP_TICK    = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    CFG_CALC_FREQ = 1'b0,
    CFG_EIGHT_BIT = 1'b1
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD0,
    ST_RD1,
    ST_INTERP,
    ST_SCALE,
    ST_ACC,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic rd1;
    logic interp;
    logic scale;
    logic acc;
    logic load_out;
    logic div_step;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } sts_t;

endpackage

[design/wavetable_voice_mixer.sv]
// Wavetable voice mixer: sample memory, voices with linear interpolation, one mixed sample
// per tick.
// Input channel (in_valid_i / in_stall_o) carries one operation per transfer: write a sample
// byte, trigger a voice, update a voice's volume and period, or mix one tick.
// Output channel (out_valid_o / out_stall_i) carries one result per tick: the clamped sum
// and the mask of voices still playing.
// Config channel (cfg_valid_i / cfg_ready_o) writes calc_freq (index 0) or eight-bit
// mode (index 1); it is always ready, and the user must see that it is written only while
// the block is idle; the block itself does not enforce this. A trigger or update with a
// nonzero period computes its step with the one-bit-per-cycle restoring divider.
// A tick walks the voices in turn, each through two memory reads, interpolate multiply,
// volume multiply and accumulate, then loads the result into the output register. The
// sample memory has one read port, so a voice's two samples are read one after the other.
// The result sits in an output register; while the receiver stalls it holds, new items are
// still taken, and a later tick waits at its end until the register is free.
// Reset clears all voices, the playing mask and the config registers; sample memory is
// not cleared and holds garbage until written.
module wavetable_voice_mixer import wvm_pkg::*; #(
  parameter int VOICES       = VOICES_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int ADDR_BITS    = ADDR_BITS_DEF,
  parameter int VOLUME_SHIFT = VOLUME_SHIFT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic [1:0]         voice_i,
  input  logic [15:0]        address_i,
  input  logic signed [7:0]  sample_value_i,
  input  logic [15:0]        sample_start_i,
  input  logic [15:0]        sample_length_i,
  input  logic [15:0]        loop_start_i,
  input  logic               looped_i,
  input  logic [6:0]         volume_i,
  input  logic [15:0]        period_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] mixed_sample_o,
  output logic [3:0]         active_voices_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

  cmd_t              cmd;
  sts_t              sts;
  logic [VIDX_W-1:0] vidx;

  assign cfg_ready_o = 1'b1;

  wvm_ctrl #(
    .VOICES(VOICES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd),
    .vidx_o      (vidx)
  );

  wvm_datapath #(
    .VOICES       (VOICES),
    .FRAC_BITS    (FRAC_BITS),
    .ADDR_BITS    (ADDR_BITS),
    .VOLUME_SHIFT (VOLUME_SHIFT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .vidx_i          (vidx),
    .operation_i     (operation_i),
    .voice_i         (voice_i),
    .address_i       (address_i),
    .sample_value_i  (sample_value_i),
    .sample_start_i  (sample_start_i),
    .sample_length_i (sample_length_i),
    .loop_start_i    (loop_start_i),
    .looped_i        (looped_i),
    .volume_i        (volume_i),
    .period_i        (period_i),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .mixed_sample_o  (mixed_sample_o),
    .active_voices_o (active_voices_o)
  );

endmodule

[design/wvm_ctrl.sv]
module wvm_ctrl import wvm_pkg::*; #(
  parameter int VOICES = VOICES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           operation_i,
  input  logic                 out_stall_i,
  input  sts_t                 sts_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  output cmd_t                 cmd_o,
  output logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] vidx_o
);

  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

  ctrl_state_e       state_q, state_d;
  logic [VIDX_W-1:0] vidx_q, vidx_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free, last_voice, is_tick;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign last_voice = (vidx_q == VIDX_W'(VOICES - 1));
  assign is_tick    = (operation_i == OP_TICK);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (is_tick) begin
            state_d = ST_RD0;
          end else if (sts_i.need_div) begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_RD0:    state_d = ST_RD1;
      ST_RD1:    state_d = ST_INTERP;
      ST_INTERP: state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_ACC;
      ST_ACC: begin
        state_d = last_voice ? ST_DONE : ST_RD0;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.rd1      = (state_q == ST_RD1);
    cmd_o.interp   = (state_q == ST_INTERP);
    cmd_o.scale    = (state_q == ST_SCALE);
    cmd_o.acc      = (state_q == ST_ACC);
    cmd_o.load_out = (state_q == ST_DONE) && out_free;
    cmd_o.div_step = (state_q == ST_DIV);
    in_stall_o     = (state_q != ST_IDLE);
    out_valid_o    = out_valid_q;
    vidx_o         = vidx_q;
  end

  always_comb begin
    vidx_d = vidx_q;
    if ((state_q == ST_IDLE) && in_valid_i && is_tick) begin
      vidx_d = '0;
    end else if (state_q == ST_ACC) begin
      vidx_d = vidx_q + VIDX_W'(1);
    end
    out_valid_d = ((state_q == ST_DONE) && out_free) || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vidx_q      <= vidx_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[design/wvm_datapath.sv]
module wvm_datapath import wvm_pkg::*; #(
  parameter int VOICES       = VOICES_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int ADDR_BITS    = ADDR_BITS_DEF,
  parameter int VOLUME_SHIFT = VOLUME_SHIFT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] vidx_i,
  input  logic [1:0]         operation_i,
  input  logic [1:0]         voice_i,
  input  logic [15:0]        address_i,
  input  logic signed [7:0]  sample_value_i,
  input  logic [15:0]        sample_start_i,
  input  logic [15:0]        sample_length_i,
  input  logic [15:0]        loop_start_i,
  input  logic               looped_i,
  input  logic [6:0]         volume_i,
  input  logic [15:0]        period_i,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output logic signed [15:0] mixed_sample_o,
  output logic [3:0]         active_voices_o
);

  localparam int VIDX_W   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int POS_W    = 16 + FRAC_BITS;
  localparam int CNT_W    = $clog2(POS_W);
  localparam int IW       = FRAC_BITS + 10;
  localparam int GW       = 8 + VOLUME_SHIFT;
  localparam int PW       = IW + GW;
  localparam int SUM_W    = PW - FRAC_BITS + $clog2(VOICES) + 1;
  localparam int AEXT     = (ADDR_BITS > 17) ? ADDR_BITS : 17;
  localparam int MASK_EXT = (VOICES > 4) ? VOICES : 4;
  localparam int MEM_D    = 1 << ADDR_BITS;

  logic [7:0]       mem_q [MEM_D];
  logic [POS_W-1:0] pos_q  [VOICES];
  logic [POS_W-1:0] step_q [VOICES];
  logic [15:0]      base_q [VOICES];
  logic [15:0]      end_q  [VOICES];
  logic [15:0]      loop_q [VOICES];
  logic             loops_q [VOICES];
  logic [6:0]       gain_q [VOICES];
  logic [VOICES-1:0] play_q;

  logic [15:0] calc_freq_q;
  logic        eight_q;

  logic [POS_W-1:0]  dq_q, dq_d;
  logic [15:0]       rem_q, rem_d;
  logic [16:0]       rem_sh;
  logic              rem_ge;
  logic [15:0]       per_q;
  logic [VIDX_W-1:0] div_v_q;
  logic [CNT_W-1:0]  cnt_q;

  logic [7:0] rdata_q, s0_q;
  logic signed [IW-1:0]    interp_q, interp_d;
  logic signed [PW-1:0]    prod_q, prod_d, shifted;
  logic signed [SUM_W-1:0] sum_q, term, sat;
  logic signed [15:0]      mixed_q;
  logic [3:0]              active_q;

  logic [VIDX_W-1:0] tv;
  logic              voice_ok, is_tv, wr_en, tick_start;
  logic [AEXT-1:0]   raddr_ext, waddr_ext;
  logic [ADDR_BITS-1:0] raddr, waddr;
  logic [15:0]       xi;
  logic [FRAC_BITS-1:0] fr;
  logic signed [8:0] diff;
  logic signed [IW-1:0] s0_x, diff_x, f_x;
  logic [GW-1:0]     g_u;
  logic [POS_W:0]    pos_sum, lim;
  logic [POS_W-1:0]  pos_nx;
  logic              stop;
  logic [MASK_EXT-1:0] m_ext;

  assign voice_ok   = ({4'b0000, voice_i} < 6'(VOICES));
  assign tv         = VIDX_W'(voice_i);
  assign is_tv      = cmd_i.accept && voice_ok &&
                      ((operation_i == OP_TRIGGER) || (operation_i == OP_UPDATE));
  assign wr_en      = cmd_i.accept && (operation_i == OP_WRITE);
  assign tick_start = cmd_i.accept && (operation_i == OP_TICK);

  assign sts_o.need_div = voice_ok && (period_i != 16'd0) &&
                          ((operation_i == OP_TRIGGER) || (operation_i == OP_UPDATE));
  assign sts_o.div_done = cmd_i.div_step && (cnt_q == CNT_W'(POS_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calc_freq_q <= '0;
      eight_q     <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_CALC_FREQ) begin
        calc_freq_q <= cfg_data_i;
      end else begin
        eight_q <= cfg_data_i[0];
      end
    end
  end

  assign rem_sh = {rem_q, dq_q[POS_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, per_q});
  assign rem_d  = rem_ge ? 16'(rem_sh - {1'b0, per_q}) : rem_sh[15:0];
  assign dq_d   = {dq_q[POS_W-2:0], rem_ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (is_tv) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_tv) begin
      dq_q    <= {calc_freq_q, {FRAC_BITS{1'b0}}};
      rem_q   <= '0;
      per_q   <= period_i;
      div_v_q <= tv;
    end else if (cmd_i.div_step) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
  end

  assign xi        = pos_q[vidx_i][POS_W-1:FRAC_BITS];
  assign fr        = pos_q[vidx_i][FRAC_BITS-1:0];
  assign raddr_ext = AEXT'(base_q[vidx_i]) + AEXT'(xi) + AEXT'(cmd_i.rd1);
  assign raddr     = raddr_ext[ADDR_BITS-1:0];
  assign waddr_ext = AEXT'(address_i);
  assign waddr     = waddr_ext[ADDR_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[waddr] <= sample_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd1) begin
      s0_q <= rdata_q;
    end
  end

  assign diff     = $signed({rdata_q[7], rdata_q}) - $signed({s0_q[7], s0_q});
  assign s0_x     = IW'($signed(s0_q));
  assign diff_x   = IW'(diff);
  assign f_x      = $signed(IW'(fr));
  assign interp_d = (s0_x <<< FRAC_BITS) + diff_x * f_x;

  assign g_u    = GW'(gain_q[vidx_i]) << VOLUME_SHIFT;
  assign prod_d = PW'(interp_q) * PW'($signed(g_u));

  assign shifted = eight_q ? (prod_q >>> (FRAC_BITS + EIGHT_SHIFT)) : (prod_q >>> FRAC_BITS);
  assign term    = SUM_W'(shifted);

  always_ff @(posedge clk_i) begin
    if (cmd_i.interp) begin
      interp_q <= interp_d;
    end
    if (cmd_i.scale) begin
      prod_q <= prod_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_start) begin
      sum_q <= '0;
    end else if (cmd_i.acc && play_q[vidx_i]) begin
      sum_q <= sum_q + term;
    end
  end

  assign pos_sum = {1'b0, pos_q[vidx_i]} + {1'b0, step_q[vidx_i]};
  assign lim     = {1'b0, end_q[vidx_i], {FRAC_BITS{1'b0}}};
  assign stop    = (pos_sum >= lim) && !loops_q[vidx_i];
  assign pos_nx  = ((pos_sum >= lim) && loops_q[vidx_i]) ?
                   {loop_q[vidx_i], {FRAC_BITS{1'b0}}} : pos_sum[POS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VOICES; i++) begin
        pos_q[i]   <= '0;
        step_q[i]  <= '0;
        base_q[i]  <= '0;
        end_q[i]   <= '0;
        loop_q[i]  <= '0;
        loops_q[i] <= 1'b0;
        gain_q[i]  <= '0;
      end
      play_q <= '0;
    end else begin
      if (is_tv) begin
        gain_q[tv] <= volume_i;
        if (period_i == 16'd0) begin
          step_q[tv] <= '0;
          play_q[tv] <= 1'b0;
        end
        if (operation_i == OP_TRIGGER) begin
          base_q[tv]  <= sample_start_i;
          end_q[tv]   <= sample_length_i;
          loop_q[tv]  <= loop_start_i;
          loops_q[tv] <= looped_i;
          pos_q[tv]   <= '0;
          if (period_i != 16'd0) begin
            play_q[tv] <= 1'b1;
          end
        end
      end
      if (sts_o.div_done) begin
        step_q[div_v_q] <= dq_d;
      end
      if (cmd_i.acc && play_q[vidx_i]) begin
        pos_q[vidx_i] <= pos_nx;
        if (stop) begin
          play_q[vidx_i] <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    sat = sum_q;
    if (eight_q) begin
      if (sum_q > SUM_W'(SAT8_MAX)) begin
        sat = SUM_W'(SAT8_MAX);
      end else if (sum_q < SUM_W'(SAT8_MIN)) begin
        sat = SUM_W'(SAT8_MIN);
      end
    end else begin
      if (sum_q > SUM_W'(SAT16_MAX)) begin
        sat = SUM_W'(SAT16_MAX);
      end else if (sum_q < SUM_W'(SAT16_MIN)) begin
        sat = SUM_W'(SAT16_MIN);
      end
    end
  end

  assign m_ext = MASK_EXT'(play_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      mixed_q  <= sat[15:0];
      active_q <= m_ext[3:0];
    end
  end

  assign mixed_sample_o  = mixed_q;
  assign active_voices_o = active_q;

endmodule

[design/wvm_checker.sv]
`include "wavetable_voice_mixer_defines.svh"

module wvm_checker import wvm_pkg::*; #(
  parameter int VOICES = VOICES_DEF
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [1:0]         operation_i,
  input logic [1:0]         voice_i,
  input logic [15:0]        period_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] mixed_sample_o,
  input logic [3:0]         active_voices_o
);

  `WVM_ASSERT_NEXT(a_tick_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && operation_i == OP_TICK, in_stall_o)
  `WVM_ASSERT_NEXT(a_div_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && (operation_i == OP_TRIGGER || operation_i == OP_UPDATE) && period_i != 16'd0 && {4'b0000, voice_i} < 6'(VOICES), in_stall_o)
  `WVM_ASSERT_SAME(a_load_busy, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))
  `WVM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(mixed_sample_o) && $stable(active_voices_o))

endmodule

bind wavetable_voice_mixer wvm_checker #(.VOICES(VOICES)) u_wvm_checker (.*);

[test/tb_wavetable_voice_mixer.sv]
module tb_wavetable_voice_mixer;
  import wvm_pkg::*;

  typedef struct {
    op_e         op;
    logic [1:0]  voice;
    logic [15:0] address;
    logic [7:0]  sval;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] lstart;
    logic        looped;
    logic [6:0]  vol;
    logic [15:0] period;
  } mix_op_t;

  typedef struct {
    logic [15:0] sample;
    logic [3:0]  mask;
  } mix_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] operation_i = '0;
  logic [1:0] voice_i = '0;
  logic [15:0] address_i = '0;
  logic signed [7:0] sample_value_i = '0;
  logic [15:0] sample_start_i = '0;
  logic [15:0] sample_length_i = '0;
  logic [15:0] loop_start_i = '0;
  logic looped_i = 1'b0;
  logic [6:0] volume_i = '0;
  logic [15:0] period_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] mixed_sample_o;
  logic [3:0] active_voices_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  wavetable_voice_mixer uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mixer image
  logic [7:0]  mem_img [0:65535];
  logic [27:0] v_pos [4];
  logic [27:0] v_step [4];
  logic [15:0] v_base [4];
  logic [15:0] v_end [4];
  logic [15:0] v_loop [4];
  logic        v_loops [4];
  logic [6:0]  v_gain [4];
  logic [3:0]  play_mask = '0;
  logic [15:0] calc_freq = '0;
  logic        eight_bit = 1'b0;

  mix_op_t  pending_ops[$];
  mix_out_t expected_mix[$];
  mix_op_t  cur;
  logic     loaded = 1'b0;
  logic     calm = 1'b0;
  int       gap = 0;
  int       stall_cnt = 0;
  int       errs = 0;
  int       n_ticks = 0;
  int       n_ops = 0;
  int       n_cfg = 0;
  int       quiet = 0;

  function automatic logic [27:0] step_for(logic [15:0] period);
    longint q;
    if (period == 0) return '0;
    q = (longint'(calc_freq) << FRAC_BITS_DEF) / longint'(period);
    return q[27:0];
  endfunction

  function automatic void mix_apply(mix_op_t t);
    longint sum, acc, s0, s1, x, f, nxt, lim;
    mix_out_t r;
    int sh;
    sum = 0;
    sh = FRAC_BITS_DEF + (eight_bit ? EIGHT_SHIFT : 0);
    case (t.op)
      OP_WRITE: mem_img[t.address] = t.sval;
      OP_TRIGGER, OP_UPDATE: begin
        v_gain[t.voice] = t.vol;
        v_step[t.voice] = step_for(t.period);
        if (t.op == OP_TRIGGER) begin
          v_base[t.voice] = t.start;
          v_end[t.voice] = t.len;
          v_loop[t.voice] = t.lstart;
          v_loops[t.voice] = t.looped;
          v_pos[t.voice] = '0;
          if (t.period != 0) play_mask[t.voice] = 1'b1;
        end
        if (t.period == 0) play_mask[t.voice] = 1'b0;
      end
      default: begin
        for (int i = 0; i < 4; i++) begin
          if (play_mask[i]) begin
            x = v_pos[i] >> FRAC_BITS_DEF;
            f = v_pos[i] & 28'hFFF;
            s0 = longint'($signed(mem_img[16'(v_base[i] + x)]));
            s1 = longint'($signed(mem_img[16'(v_base[i] + x + 1)]));
            acc = (s0 * (4096 - f) + s1 * f) * longint'(v_gain[i]);
            sum += acc >>> sh;
            nxt = longint'(v_pos[i]) + longint'(v_step[i]);
            lim = longint'(v_end[i]) << FRAC_BITS_DEF;
            if (nxt >= lim) begin
              if (v_loops[i]) nxt = longint'(v_loop[i]) << FRAC_BITS_DEF;
              else play_mask[i] = 1'b0;
            end
            v_pos[i] = nxt[27:0];
          end
        end
        if (eight_bit) begin
          if (sum > SAT8_MAX) sum = SAT8_MAX;
          else if (sum < SAT8_MIN) sum = SAT8_MIN;
        end else begin
          if (sum > SAT16_MAX) sum = SAT16_MAX;
          else if (sum < SAT16_MIN) sum = SAT16_MIN;
        end
        r.sample = sum[15:0];
        r.mask = play_mask;
        expected_mix.push_back(r);
        n_ticks++;
      end
    endcase
  endfunction

  // sender
  always @(posedge clk_i) begin
    if (loaded && !in_stall_o) begin
      mix_apply(cur);
      n_ops++;
      loaded = 1'b0;
      gap = calm ? 0 : $urandom_range(0, 11);
    end
    if (!loaded) begin
      if (gap > 0) gap--;
      else if (pending_ops.size() != 0) begin
        cur = pending_ops.pop_front();
        loaded = 1'b1;
      end
    end
    in_valid_i <= loaded;
    operation_i <= cur.op;
    voice_i <= cur.voice;
    address_i <= cur.address;
    sample_value_i <= cur.sval;
    sample_start_i <= cur.start;
    sample_length_i <= cur.len;
    loop_start_i <= cur.lstart;
    looped_i <= cur.looped;
    volume_i <= cur.vol;
    period_i <= cur.period;
  end

  // receiver
  always @(posedge clk_i) begin
    mix_out_t e;
    if (out_valid_o && !out_stall_i) begin
      stall_cnt = calm ? 0 : $urandom_range(0, 11);
      if (expected_mix.size() == 0) begin
        errs++;
        if (errs <= 10) $display("unexpected transfer: sample %0d mask %h",
                                 mixed_sample_o, active_voices_o);
      end else begin
        e = expected_mix.pop_front();
        if (mixed_sample_o !== e.sample || active_voices_o !== e.mask) begin
          errs++;
          if (errs <= 10)
            $display("mismatch: sample exp %0d got %0d, mask exp %h got %h",
                     $signed(e.sample), mixed_sample_o, e.mask, active_voices_o);
        end
      end
    end else if (stall_cnt > 0) stall_cnt--;
    out_stall_i <= (stall_cnt != 0);
  end

  // config channel
  always @(posedge clk_i) begin
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_e'(cfg_index_i) == CFG_CALC_FREQ) calc_freq = cfg_data_i;
      else eight_bit = cfg_data_i[0];
      n_cfg++;
      cfg_valid_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= 20000) begin
      $display("watchdog: no transfer for %0d cycles", quiet);
      $display("tb_wavetable_voice_mixer: done, errors");
      $finish;
    end
  end

  task automatic drain();
    wait (pending_ops.size() == 0 && !loaded && expected_mix.size() == 0);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_e idx, logic [15:0] data);
    drain();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    wait (!cfg_valid_i);
  endtask

  function automatic mix_op_t blank(op_e op);
    mix_op_t t;
    t.op = op;
    t.voice = '0; t.address = '0; t.sval = '0; t.start = '0; t.len = '0;
    t.lstart = '0; t.looped = 1'b0; t.vol = '0; t.period = '0;
    return t;
  endfunction

  function automatic mix_op_t voice_op(op_e op, logic [1:0] v, logic [15:0] st,
                                       logic [15:0] ln, logic [15:0] lp, logic lo,
                                       logic [6:0] vol, logic [15:0] per);
    mix_op_t t;
    t = blank(op);
    t.voice = v; t.start = st; t.len = ln; t.lstart = lp; t.looped = lo;
    t.vol = vol; t.period = per;
    return t;
  endfunction

  function automatic logic [15:0] safe_addr();
    return $urandom_range(0, 1) ? 16'($urandom_range(0, 42)) :
                                  16'($urandom_range(65504, 65535));
  endfunction

  function automatic mix_op_t rand_op();
    mix_op_t t;
    int k;
    k = $urandom_range(0, 99);
    t = blank(OP_TICK);
    t.voice = $urandom; t.address = $urandom; t.sval = $urandom;
    if (k < 20) begin
      t.op = OP_WRITE;
      if ($urandom_range(0, 7) != 0) t.address = safe_addr();
    end else if (k < 33) begin
      // voices stay inside the preloaded region
      t = voice_op(OP_TRIGGER, $urandom, safe_addr(), $urandom_range(0, 20),
                   $urandom_range(0, 20), $urandom, $urandom_range(0, 3) == 0 ?
                   7'($urandom) : 7'($urandom_range(0, 64)), $urandom);
      if ($urandom_range(0, 5) == 0) t.period = 0;
      else if ($urandom_range(0, 1)) t.period = calc_freq + $urandom_range(0, 8000);
    end else if (k < 38) begin
      t = voice_op(OP_TRIGGER, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, 16'h0);
    end else if (k < 45) begin
      t = voice_op(OP_UPDATE, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom);
      if ($urandom_range(0, 4) == 0) t.period = 0;
    end
    return t;
  endfunction

  task automatic random_phase(int n, logic quiet_sides);
    drain();
    calm = quiet_sides;
    repeat (n) pending_ops.push_back(rand_op());
    drain();
    calm = 1'b0;
  endtask

  initial begin
    mix_op_t t;
    for (int i = 0; i < 4; i++) begin
      v_pos[i] = '0; v_step[i] = '0; v_base[i] = '0; v_end[i] = '0;
      v_loop[i] = '0; v_loops[i] = 1'b0; v_gain[i] = '0;
    end
    cur = blank(OP_WRITE);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cfg_write(CFG_CALC_FREQ, 16'd4096);
    cfg_write(CFG_EIGHT_BIT, 16'd0);
    for (int a = 0; a < 64; a++) begin
      t = blank(OP_WRITE);
      t.address = a;
      t.sval = a < 8 ? 8'sd127 : (a < 16 ? -8'sd128 : 8'($urandom));
      pending_ops.push_back(t);
    end
    for (int a = 65504; a < 65536; a++) begin
      t = blank(OP_WRITE);
      t.address = a;
      t.sval = $urandom;
      pending_ops.push_back(t);
    end

    pending_ops.push_back(blank(OP_TICK));
    pending_ops.push_back(voice_op(OP_TRIGGER, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1,
                                   7'h7F, 16'd0));
    pending_ops.push_back(voice_op(OP_UPDATE, 0, 0, 0, 0, 0, 7'd64, 16'd5));
    pending_ops.push_back(voice_op(OP_TRIGGER, 3, 0, 0, 0, 0, 7'd64, 16'd1));
    pending_ops.push_back(blank(OP_TICK));
    pending_ops.push_back(blank(OP_TICK));
    for (int v = 0; v < 4; v++)
      pending_ops.push_back(voice_op(OP_TRIGGER, v, 0, 6, 0, 1, 7'h7F, 16'd8192));
    pending_ops.push_back(blank(OP_TICK));
    pending_ops.push_back(blank(OP_TICK));
    for (int v = 0; v < 4; v++)
      pending_ops.push_back(voice_op(OP_TRIGGER, v, 8, 6, 2, v[0], 7'h7F, 16'd65535));
    pending_ops.push_back(blank(OP_TICK));
    pending_ops.push_back(voice_op(OP_UPDATE, 2, 0, 0, 0, 0, 7'd10, 16'd0));
    pending_ops.push_back(voice_op(OP_TRIGGER, 1, 16'd65530, 10, 3, 1, 7'd64, 16'd1000));
    pending_ops.push_back(blank(OP_TICK));
    pending_ops.push_back(blank(OP_TICK));
    pending_ops.push_back(blank(OP_TICK));
    drain();

    cfg_write(CFG_CALC_FREQ, 16'hFFFF);
    pending_ops.push_back(voice_op(OP_TRIGGER, 2, 20, 3, 1, 1, 7'd64, 16'd1));
    pending_ops.push_back(blank(OP_TICK));
    pending_ops.push_back(blank(OP_TICK));
    random_phase(250, 1'b0);

    cfg_write(CFG_EIGHT_BIT, 16'd1);
    cfg_write(CFG_CALC_FREQ, 16'd0);
    random_phase(150, 1'b0);
    cfg_write(CFG_CALC_FREQ, 16'($urandom));
    random_phase(250, 1'b1);
    cfg_write(CFG_EIGHT_BIT, 16'hFFFE);
    cfg_write(CFG_CALC_FREQ, 16'($urandom_range(1000, 9000)));
    random_phase(300, 1'b0);
    cfg_write(CFG_EIGHT_BIT, 16'd1);
    random_phase(250, 1'b0);
    cfg_write(CFG_EIGHT_BIT, 16'd0);
    cfg_write(CFG_CALC_FREQ, 16'($urandom));
    random_phase(300, 1'b0);
    drain();

    $display("covered %0d operations, %0d mixed ticks, %0d register writes",
             n_ops, n_ticks, n_cfg);
    $display("both output modes, calc_freq from 0 to full scale, random idling");
    if (errs == 0 && expected_mix.size() == 0) begin
      $display("tb_wavetable_voice_mixer: done, clean");
    end else begin
      $display("%0d mismatches, %0d results missing", errs, expected_mix.size());
      $display("tb_wavetable_voice_mixer: done, errors");
    end
    $finish;
  end

endmodule
